@@ design/modular_multiply_64_top_macros.svh @@
// assertion macros shared by the modular multiply design files
`ifndef MODULAR_MULTIPLY_64_TOP_MACROS_SVH
`define MODULAR_MULTIPLY_64_TOP_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define MM64_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mm64 same-cycle check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define MM64_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mm64 next-cycle check failed");

`endif

@@ design/mm64_pkg.sv @@
// shared types, constants and modular add for the modular multiply pipeline
`timescale 1ns / 1ps
`default_nettype none

package mm64_pkg;

    // operand width in bits
    localparam int WIDTH = 64;

    // request travelling down the cell chain
    typedef struct packed {
        logic [WIDTH-1:0] op;       // multiplicand bits, later the reduced multiplicand
        logic [WIDTH-1:0] mul;      // multiplier, consumed from the top bit
        logic [WIDTH-1:0] modulus;  // modulus, zero means plain wrap-around
        logic [WIDTH-1:0] acc;      // running remainder
    } t_mm_item;

    // (x + y + cin) mod m for x, y below m; zero modulus gives the wrapped sum
    function automatic logic [WIDTH-1:0] mm64_mod_add(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic             cin,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0]   sum;
        logic [WIDTH+1:0] diff;
        sum  = {1'b0, x} + {1'b0, y} + {{WIDTH{1'b0}}, cin};
        diff = {1'b0, sum} - {2'b00, m};
        return diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/modular_multiply_64_top.sv @@
// Modular multiply, (multiplicand * multiplier) mod modulus over the exact 128-bit
// product; a zero modulus returns the low 64 bits of the product. One request is
// taken every clock cycle unless the chain stalls. A chain of 64 reduction cells
// first brings the multiplicand below the modulus one bit per cell, then a chain of
// 64 multiply cells handles one multiplier bit each in two registered halves (double,
// then conditional add), and a final output register holds the result. The chain
// stalls only when the output register holds an untaken result and the last cell
// also holds one.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_multiply_64_top_macros.svh"

module modular_multiply_64_top
    import mm64_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [3*WIDTH-1:0] s_axis_tdata,  // multiplicand, multiplier, modulus
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [WIDTH-1:0]        m_axis_tdata   // remainder
);

    logic                 w_adv;
    logic                 w_out_free;
    logic     [WIDTH:0]   w_rd_valid;
    t_mm_item             w_rd_item [WIDTH+1];
    logic     [WIDTH:0]   w_ml_valid;
    t_mm_item             w_ml_item [WIDTH+1];
    logic                 r_out_valid;
    logic     [WIDTH-1:0] r_out_data;

    // chain moves unless both output register and last cell are full and stalled
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = w_out_free || !w_ml_valid[WIDTH];
    assign s_axis_tready = w_adv;

    // request unpacked into the first reduction cell
    assign w_rd_valid[0]        = s_axis_tvalid;
    assign w_rd_item[0].op      = s_axis_tdata[WIDTH-1:0];
    assign w_rd_item[0].mul     = s_axis_tdata[2*WIDTH-1:WIDTH];
    assign w_rd_item[0].modulus = s_axis_tdata[3*WIDTH-1:2*WIDTH];
    assign w_rd_item[0].acc     = '0;

    // multiplicand reduction chain
    for (genvar k = 0; k < WIDTH; k++) begin : g_rd
        mm64_reduce_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_rd_valid[k]),
            .i_item  (w_rd_item[k]),
            .o_valid (w_rd_valid[k+1]),
            .o_item  (w_rd_item[k+1])
        );
    end

    // reduced multiplicand becomes the operand, remainder restarts at zero
    assign w_ml_valid[0]        = w_rd_valid[WIDTH];
    assign w_ml_item[0].op      = w_rd_item[WIDTH].acc;
    assign w_ml_item[0].mul     = w_rd_item[WIDTH].mul;
    assign w_ml_item[0].modulus = w_rd_item[WIDTH].modulus;
    assign w_ml_item[0].acc     = '0;

    // interleaved multiply chain, top multiplier bit first
    for (genvar k = 0; k < WIDTH; k++) begin : g_ml
        mm64_mult_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_ml_valid[k]),
            .i_item  (w_ml_item[k]),
            .o_valid (w_ml_valid[k+1]),
            .o_item  (w_ml_item[k+1])
        );
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_ml_valid[WIDTH];
        end
    end

    // output register data
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= w_ml_item[WIDTH].acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // an accepted request lands in the first cell
    `MM64_ASSERT_NEXT(a_top_accept_enters, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, w_rd_valid[1])

    // a stall only happens with both output register and last cell full
    `MM64_ASSERT_NOW(a_top_stall_full, i_clk, i_rst_n,
        !w_adv, r_out_valid && w_ml_valid[WIDTH] && !m_axis_tready)

    // a held result is only dropped after being taken
    `MM64_ASSERT_NOW(a_top_out_taken, i_clk, i_rst_n,
        $fell(r_out_valid), $past(m_axis_tready))

endmodule

`default_nettype wire

@@ design/mm64_reduce_cell.sv @@
// one bit step of the multiplicand reduction: acc = (2*acc + op msb) mod m
`timescale 1ns / 1ps
`default_nettype none
`include "modular_multiply_64_top_macros.svh"

module mm64_reduce_cell
    import mm64_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_mm_item i_item,
    output logic          o_valid,
    output t_mm_item      o_item
);

    logic     r_valid;
    t_mm_item r_item;
    t_mm_item n_item;

    // shift the top multiplicand bit into the running remainder
    always_comb begin
        n_item     = i_item;
        n_item.acc = mm64_mod_add(i_item.acc, i_item.acc, i_item.op[WIDTH-1],
                                  i_item.modulus);
        n_item.op  = {i_item.op[WIDTH-2:0], 1'b0};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // remainder stays below a nonzero modulus
    `MM64_ASSERT_NOW(a_rd_acc_below_mod, i_clk, i_rst_n,
        r_valid && (r_item.modulus != '0), r_item.acc < r_item.modulus)

endmodule

`default_nettype wire

@@ design/mm64_mult_cell.sv @@
// one multiplier bit of interleaved modular multiply: double, then add
`timescale 1ns / 1ps
`default_nettype none
`include "modular_multiply_64_top_macros.svh"

module mm64_mult_cell
    import mm64_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_mm_item i_item,
    output logic          o_valid,
    output t_mm_item      o_item
);

    logic     r_mid_valid;
    t_mm_item r_mid_item;
    logic     r_valid;
    t_mm_item r_item;
    t_mm_item n_mid_item;
    t_mm_item n_item;

    // first half: double the remainder
    always_comb begin
        n_mid_item     = i_item;
        n_mid_item.acc = mm64_mod_add(i_item.acc, i_item.acc, 1'b0, i_item.modulus);
    end

    // second half: add the reduced multiplicand when the multiplier bit is set
    always_comb begin
        n_item     = r_mid_item;
        n_item.acc = mm64_mod_add(r_mid_item.acc,
                                  r_mid_item.mul[WIDTH-1] ? r_mid_item.op : '0,
                                  1'b0, r_mid_item.modulus);
        n_item.mul = {r_mid_item.mul[WIDTH-2:0], 1'b0};
    end

    // valid flags of both halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else if (i_en) begin
            r_mid_valid <= i_valid;
            r_valid     <= r_mid_valid;
        end
    end

    // payload of both halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid_item <= n_mid_item;
            r_item     <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // remainder stays below a nonzero modulus
    `MM64_ASSERT_NOW(a_ml_acc_below_mod, i_clk, i_rst_n,
        r_valid && (r_item.modulus != '0), r_item.acc < r_item.modulus)

endmodule

`default_nettype wire
